>>> rtl/xtt_pkg.sv
// Package: codes, characters and markup table for the XML tag tokeniser.
`default_nettype none
package xtt_pkg;

    localparam int NAME_LEN_DEF   = 64;
    localparam int DEPTH_BITS_DEF = 8;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_NAME   = 2'd1,
        MODE_ATTR   = 2'd2,
        MODE_MARKUP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CLS_TEXT   = 3'd0,
        CLS_OPEN   = 3'd1,
        CLS_NAME   = 3'd2,
        CLS_ATTR   = 3'd3,
        CLS_QUOTED = 3'd4,
        CLS_CLOSE  = 3'd5,
        CLS_MARKUP = 3'd6
    } cls_t;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // markup automaton positions
    localparam logic [4:0] MK_IDLE         = 5'd0;
    localparam logic [4:0] MK_AFTER_BANG   = 5'd1;
    localparam logic [4:0] MK_COMMENT_BODY = 5'd3;
    localparam logic [4:0] MK_COMMENT_END  = 5'd5;
    localparam logic [4:0] MK_CDATA        = 5'd8;
    localparam logic [4:0] MK_CDATA_HEAD   = 5'd13;
    localparam logic [4:0] MK_CDATA_BODY   = 5'd14;
    localparam logic [4:0] MK_CDATA_END    = 5'd16;
    localparam logic [4:0] MK_DECL         = 5'd18;

    // "!----> [CDATA[]]> > ", a space marks an end position
    function automatic logic [7:0] mk_char(input logic [4:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            5'd0:    ch = CH_BANG;
            5'd1:    ch = CH_DASH;
            5'd2:    ch = CH_DASH;
            5'd3:    ch = CH_DASH;
            5'd4:    ch = CH_DASH;
            5'd5:    ch = CH_GT;
            5'd6:    ch = CH_SPACE;
            5'd7:    ch = CH_LBR;
            5'd8:    ch = 8'h43;
            5'd9:    ch = 8'h44;
            5'd10:   ch = 8'h41;
            5'd11:   ch = 8'h54;
            5'd12:   ch = 8'h41;
            5'd13:   ch = CH_LBR;
            5'd14:   ch = CH_RBR;
            5'd15:   ch = CH_RBR;
            5'd16:   ch = CH_GT;
            5'd17:   ch = CH_SPACE;
            5'd18:   ch = CH_GT;
            5'd19:   ch = CH_SPACE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> rtl/xml_tag_tokenizer_top.sv
// XML tag tokeniser: per-byte classification, tag flags and nesting depth.
//
// One word in, one word out. Each byte passes an input register, then
// combinational classification against the scan state, and lands in the
// result register. One byte per cycle is sustained while the output is
// not stalled, with the scan state (mode, quote flags, name counter, depth
// counter) updated as each byte advances. While a result waits to be
// taken the input register still takes one word; with both registers full
// the input stalls. After the word marked last, all scan state returns to
// its reset values.
`default_nettype none
module xml_tag_tokenizer_top
    import xtt_pkg::*;
#(
    parameter int NAME_LEN   = NAME_LEN_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      byte_value,
    output logic [2:0]      byte_class,
    output logic [5:0]      name_pos,
    output logic            end_tag,
    output logic            self_closed,
    output logic [7:0]      depth,
    output logic            depth_error,
    output logic            last_out
);

    localparam int NCW  = $clog2(NAME_LEN + 1);
    localparam int POSX = (NCW > 6) ? NCW : 6;
    localparam int DEXT = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;
    localparam logic [NCW-1:0] NC_MAX  = NCW'(NAME_LEN);
    localparam logic [NCW-1:0] POS_MAX = NCW'(NAME_LEN - 1);
    localparam logic [DEPTH_BITS-1:0] DMAX = '1;

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       adv;
    logic       in_acc;

    // scan state
    mode_t                 mode_reg,    mode_next;
    logic [4:0]            mk_reg,      mk_next;
    logic                  dq_reg,      dq_next;
    logic                  sq_reg,      sq_next;
    logic                  slash_reg,   slash_next;
    logic [NCW-1:0]        nc_reg,      nc_next;
    logic                  closing_reg, closing_next;
    logic [DEPTH_BITS-1:0] nest_reg,    nest_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] byte_value_reg;
    cls_t       cls_reg;
    logic [5:0] name_pos_reg;
    logic       end_tag_reg;
    logic       self_closed_reg;
    logic [7:0] depth_reg;
    logic       depth_error_reg;
    logic       last_out_reg;

    // combinational results
    cls_t            cls_w;
    logic [NCW-1:0]  pos_w;
    logic [POSX-1:0] pos_ext;
    logic [DEXT-1:0] depth_ext;
    logic            et_w, sc_w, err_w, do_close, closing_w, name_empty;
    logic [4:0]      mk_i;
    logic [7:0]      c;

    assign adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign in_acc = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= last;
        end
    end

    assign c          = s1_byte_reg;
    assign name_empty = (nc_reg == '0);

    always_comb
    begin
        mode_next    = mode_reg;
        mk_next      = mk_reg;
        dq_next      = dq_reg;
        sq_next      = sq_reg;
        slash_next   = slash_reg;
        nc_next      = nc_reg;
        closing_next = closing_reg;
        nest_next    = nest_reg;
        cls_w        = CLS_TEXT;
        pos_w        = '0;
        et_w         = 1'b0;
        sc_w         = 1'b0;
        err_w        = 1'b0;
        do_close     = 1'b0;
        closing_w    = closing_reg || name_empty;
        mk_i         = (mk_reg > MK_DECL) ? MK_DECL : mk_reg;

        unique case (mode_reg)
            MODE_TEXT:
            begin
                if (c == CH_LT)
                begin
                    cls_w        = CLS_OPEN;
                    mode_next    = MODE_NAME;
                    nc_next      = '0;
                    closing_next = 1'b0;
                    slash_next   = 1'b0;
                    dq_next      = 1'b0;
                    sq_next      = 1'b0;
                end
            end
            MODE_NAME:
            begin
                if (name_empty && c == CH_BANG)
                begin
                    cls_w     = CLS_MARKUP;
                    mode_next = MODE_MARKUP;
                    mk_next   = MK_AFTER_BANG;
                end
                else if (c == CH_GT)
                begin
                    do_close = 1'b1;
                end
                else if (c == CH_SPACE || c == CH_LF || c == CH_TAB)
                begin
                    cls_w      = CLS_ATTR;
                    mode_next  = MODE_ATTR;
                    slash_next = 1'b0;
                    et_w       = closing_w;
                end
                else
                begin
                    cls_w = CLS_NAME;
                    pos_w = (nc_reg < POS_MAX) ? nc_reg : POS_MAX;
                    if (name_empty && c == CH_SLASH)
                    begin
                        closing_next = 1'b1;
                    end
                    if (nc_reg < NC_MAX)
                    begin
                        nc_next = nc_reg + 1'b1;
                    end
                    et_w       = closing_next;
                    slash_next = (c == CH_SLASH);
                end
            end
            MODE_ATTR:
            begin
                priority if (dq_reg)
                begin
                    cls_w = CLS_QUOTED;
                    if (c == CH_DQ) dq_next = 1'b0;
                end
                else if (sq_reg)
                begin
                    cls_w = CLS_QUOTED;
                    if (c == CH_SQ) sq_next = 1'b0;
                end
                else if (c == CH_GT)
                begin
                    do_close = 1'b1;
                end
                else if (c == CH_DQ)
                begin
                    cls_w   = CLS_QUOTED;
                    dq_next = 1'b1;
                end
                else if (c == CH_SQ)
                begin
                    cls_w   = CLS_QUOTED;
                    sq_next = 1'b1;
                end
                else
                begin
                    cls_w = CLS_ATTR;
                end
                if (!do_close)
                begin
                    slash_next = (c == CH_SLASH);
                    et_w       = closing_w;
                end
            end
            MODE_MARKUP:
            begin
                cls_w = CLS_MARKUP;
                priority if (c == mk_char(mk_i))          mk_i = mk_i + 5'd1;
                else if (mk_i == MK_AFTER_BANG && c == CH_LBR) mk_i = MK_CDATA;
                else if (mk_i < MK_COMMENT_BODY)          mk_i = MK_DECL;
                else if (mk_i == MK_COMMENT_END && c == CH_DASH) mk_i = MK_COMMENT_END;
                else if (mk_i <= MK_COMMENT_END)          mk_i = MK_COMMENT_BODY;
                else if (mk_i <= MK_CDATA_HEAD)           mk_i = MK_DECL;
                else if (mk_i == MK_CDATA_END && c == CH_RBR) mk_i = MK_CDATA_END;
                else if (mk_i <= MK_CDATA_END)            mk_i = MK_CDATA_BODY;
                else                                      mk_i = MK_DECL;
                if (mk_char(mk_i) == CH_SPACE || (mk_i == MK_DECL && c == CH_GT))
                begin
                    mode_next = MODE_TEXT;
                    mk_next   = MK_IDLE;
                end
                else
                begin
                    mk_next = mk_i;
                end
            end
            default:
            begin
                mode_next = MODE_TEXT;
            end
        endcase

        if (do_close)
        begin
            cls_w = CLS_CLOSE;
            et_w  = closing_w;
            sc_w  = !closing_w && slash_reg;
            if (closing_w)
            begin
                if (nest_reg == '0) err_w = 1'b1;
                else nest_next = nest_reg - 1'b1;
            end
            else if (!sc_w)
            begin
                if (nest_reg == DMAX) err_w = 1'b1;
                else nest_next = nest_reg + 1'b1;
            end
            mode_next  = MODE_TEXT;
            dq_next    = 1'b0;
            sq_next    = 1'b0;
            slash_next = 1'b0;
        end
    end

    assign pos_ext   = POSX'(pos_w);
    assign depth_ext = DEXT'(nest_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_TEXT;
            mk_reg      <= MK_IDLE;
            dq_reg      <= 1'b0;
            sq_reg      <= 1'b0;
            slash_reg   <= 1'b0;
            nc_reg      <= '0;
            closing_reg <= 1'b0;
            nest_reg    <= '0;
        end
        else if (adv)
        begin
            if (s1_last_reg)
            begin
                mode_reg    <= MODE_TEXT;
                mk_reg      <= MK_IDLE;
                dq_reg      <= 1'b0;
                sq_reg      <= 1'b0;
                slash_reg   <= 1'b0;
                nc_reg      <= '0;
                closing_reg <= 1'b0;
                nest_reg    <= '0;
            end
            else
            begin
                mode_reg    <= mode_next;
                mk_reg      <= mk_next;
                dq_reg      <= dq_next;
                sq_reg      <= sq_next;
                slash_reg   <= slash_next;
                nc_reg      <= nc_next;
                closing_reg <= closing_next;
                nest_reg    <= nest_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byte_value_reg  <= c;
            cls_reg         <= cls_w;
            name_pos_reg    <= pos_ext[5:0];
            end_tag_reg     <= et_w;
            self_closed_reg <= sc_w;
            depth_reg       <= depth_ext[7:0];
            depth_error_reg <= err_w;
            last_out_reg    <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_value  = byte_value_reg;
    assign byte_class  = cls_reg;
    assign name_pos    = name_pos_reg;
    assign end_tag     = end_tag_reg;
    assign self_closed = self_closed_reg;
    assign depth       = depth_reg;
    assign depth_error = depth_error_reg;
    assign last_out    = last_out_reg;

    a_err_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_error |-> byte_class == CLS_CLOSE)
        else $error("depth error on a non-close word");

    a_self_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && self_closed |-> !end_tag && byte_class == CLS_CLOSE)
        else $error("self-closed flag on a closing tag");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_last_reg |=> mode_reg == MODE_TEXT && nest_reg == '0 && nc_reg == '0)
        else $error("scan state not cleared after last word");

endmodule
`default_nettype wire

>>> tb/xtt_token_checker.sv
// Checker: predicts each classified word of the XML tag tokeniser and compares it.
module xtt_token_checker
    import xtt_pkg::*;
#(
    parameter int NAME_LEN   = NAME_LEN_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] byte_value,
    input  logic [2:0] byte_class,
    input  logic [5:0] name_pos,
    input  logic       end_tag,
    input  logic       self_closed,
    input  logic [7:0] depth,
    input  logic       depth_error,
    input  logic       last_out,
    output int         errors,
    output int         pending,
    output int         checked,
    output int         saturations,
    output int         peak_depth
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] byte_value;
        cls_t       byte_class;
        logic [5:0] name_pos;
        logic       end_tag;
        logic       self_closed;
        logic [7:0] depth;
        logic       depth_error;
        logic       last_out;
    } word_t;

    // end positions of the markup automaton are marked by a space
    localparam logic [8*20-1:0] MARKUP_SEQ = "!----> [CDATA[]]> > ";

    word_t      expected_words[$];
    word_t      got;
    word_t      want;

    mode_t      scan_mode;
    logic [4:0] mk_pos;
    logic       in_dq;
    logic       in_sq;
    logic       prev_slash;
    int         name_cnt;
    logic       closing_tag;
    int         nest;

    function automatic logic [7:0] seq_char(input logic [4:0] i);
        return MARKUP_SEQ[8*(19-i) +: 8];
    endfunction

    task automatic reset_scan();
        scan_mode   = MODE_TEXT;
        mk_pos      = MK_IDLE;
        in_dq       = 1'b0;
        in_sq       = 1'b0;
        prev_slash  = 1'b0;
        name_cnt    = 0;
        closing_tag = 1'b0;
        nest        = 0;
    endtask

    // one step of the comment / CDATA / declaration matcher; 1 when markup ends
    function automatic logic markup_step(input logic [7:0] c);
        logic [4:0] i;
        i = mk_pos;
        if (i > MK_DECL)
            i = MK_DECL;
        if (c == seq_char(i))
            i++;
        else if (i == MK_AFTER_BANG && c == CH_LBR)
            i = MK_CDATA;
        else if (i < MK_COMMENT_BODY)
            i = MK_DECL;
        else if (i == MK_COMMENT_END && c == CH_DASH)
            i = MK_COMMENT_END;
        else if (i <= MK_COMMENT_END)
            i = MK_COMMENT_BODY;
        else if (i <= MK_CDATA_HEAD)
            i = MK_DECL;
        else if (i == MK_CDATA_END && c == CH_RBR)
            i = MK_CDATA_END;
        else if (i <= MK_CDATA_END)
            i = MK_CDATA_BODY;
        else
            i = MK_DECL;
        mk_pos = i[4:0];
        return (seq_char(i) == CH_SPACE) || (i == MK_DECL && c == CH_GT);
    endfunction

    task automatic classify_byte(input logic [7:0] c, input logic lst);
        word_t r;
        logic  do_close;
        logic  closing;
        int    pos;
        int    dmax;
        r            = '0;
        r.byte_value = c;
        r.last_out   = lst;
        r.byte_class = CLS_TEXT;
        do_close     = 1'b0;
        dmax         = (1 << DEPTH_BITS) - 1;
        case (scan_mode)
            MODE_TEXT:
            begin
                if (c == CH_LT)
                begin
                    r.byte_class = CLS_OPEN;
                    scan_mode    = MODE_NAME;
                    name_cnt     = 0;
                    closing_tag  = 1'b0;
                    prev_slash   = 1'b0;
                    in_dq        = 1'b0;
                    in_sq        = 1'b0;
                end
            end
            MODE_NAME:
            begin
                if (name_cnt == 0 && c == CH_BANG)
                begin
                    r.byte_class = CLS_MARKUP;
                    scan_mode    = MODE_MARKUP;
                    mk_pos       = MK_AFTER_BANG;
                end
                else if (c == CH_GT)
                    do_close = 1'b1;
                else if (c == CH_SPACE || c == CH_LF || c == CH_TAB)
                begin
                    r.byte_class = CLS_ATTR;
                    scan_mode    = MODE_ATTR;
                    prev_slash   = 1'b0;
                    r.end_tag    = closing_tag || name_cnt == 0;
                end
                else
                begin
                    r.byte_class = CLS_NAME;
                    pos          = (name_cnt < NAME_LEN - 1) ? name_cnt : NAME_LEN - 1;
                    r.name_pos   = pos[5:0];
                    if (name_cnt == 0 && c == CH_SLASH)
                        closing_tag = 1'b1;
                    if (name_cnt < NAME_LEN)
                        name_cnt++;
                    r.end_tag  = closing_tag;
                    prev_slash = (c == CH_SLASH);
                end
            end
            MODE_ATTR:
            begin
                if (in_dq)
                begin
                    r.byte_class = CLS_QUOTED;
                    if (c == CH_DQ)
                        in_dq = 1'b0;
                end
                else if (in_sq)
                begin
                    r.byte_class = CLS_QUOTED;
                    if (c == CH_SQ)
                        in_sq = 1'b0;
                end
                else if (c == CH_GT)
                    do_close = 1'b1;
                else if (c == CH_DQ)
                begin
                    r.byte_class = CLS_QUOTED;
                    in_dq        = 1'b1;
                end
                else if (c == CH_SQ)
                begin
                    r.byte_class = CLS_QUOTED;
                    in_sq        = 1'b1;
                end
                else
                    r.byte_class = CLS_ATTR;
                if (!do_close)
                begin
                    prev_slash = (c == CH_SLASH);
                    r.end_tag  = closing_tag || name_cnt == 0;
                end
            end
            default:
            begin
                r.byte_class = CLS_MARKUP;
                if (markup_step(c))
                begin
                    scan_mode = MODE_TEXT;
                    mk_pos    = MK_IDLE;
                end
            end
        endcase

        if (do_close)
        begin
            closing       = closing_tag || name_cnt == 0;
            r.byte_class  = CLS_CLOSE;
            r.end_tag     = closing;
            r.self_closed = !closing && prev_slash;
            if (closing)
            begin
                if (nest == 0)
                    r.depth_error = 1'b1;
                else
                    nest--;
            end
            else if (!r.self_closed)
            begin
                if (nest >= dmax)
                begin
                    r.depth_error = 1'b1;
                    nest          = dmax;
                end
                else
                    nest++;
            end
            scan_mode  = MODE_TEXT;
            in_dq      = 1'b0;
            in_sq      = 1'b0;
            prev_slash = 1'b0;
        end

        r.depth = nest[7:0];
        if (r.depth_error)
            saturations++;
        if (nest > peak_depth)
            peak_depth = nest;
        expected_words.push_back(r);
        if (lst)
            reset_scan();
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] seen,
                                   input logic [7:0] wanted);
        $display("%t mismatch on %s: got %0h, expected %0h (word %0d)",
                 $realtime, what, seen, wanted, checked);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_scan();
            expected_words.delete();
            errors      = 0;
            pending     = 0;
            checked     = 0;
            saturations = 0;
            peak_depth  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.byte_value  = byte_value;
                got.byte_class  = cls_t'(byte_class);
                got.name_pos    = name_pos;
                got.end_tag     = end_tag;
                got.self_closed = self_closed;
                got.depth       = depth;
                got.depth_error = depth_error;
                got.last_out    = last_out;
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", byte_value, 8'h00);
                else
                begin
                    want = expected_words.pop_front();
                    if (got.byte_value !== want.byte_value)
                        report_mismatch("byte_value", got.byte_value, want.byte_value);
                    if (got.byte_class !== want.byte_class)
                        report_mismatch("byte_class", 8'(got.byte_class),
                                        8'(want.byte_class));
                    if (got.name_pos !== want.name_pos)
                        report_mismatch("name_pos", 8'(got.name_pos), 8'(want.name_pos));
                    if (got.end_tag !== want.end_tag)
                        report_mismatch("end_tag", 8'(got.end_tag), 8'(want.end_tag));
                    if (got.self_closed !== want.self_closed)
                        report_mismatch("self_closed", 8'(got.self_closed),
                                        8'(want.self_closed));
                    if (got.depth !== want.depth)
                        report_mismatch("depth", got.depth, want.depth);
                    if (got.depth_error !== want.depth_error)
                        report_mismatch("depth_error", 8'(got.depth_error),
                                        8'(want.depth_error));
                    if (got.last_out !== want.last_out)
                        report_mismatch("last_out", 8'(got.last_out), 8'(want.last_out));
                    checked++;
                end
            end
            if (in_valid && !in_stall)
                classify_byte(in_byte, last);
            pending = expected_words.size();
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top: XML byte streams, idle and stall phases, verdict.
module tb;
    import xtt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_LEN    = 120;
    localparam int RANDOM_STOP = 1450;

    typedef enum logic [2:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       last      = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] byte_value;
    logic [2:0] byte_class;
    logic [5:0] name_pos;
    logic       end_tag;
    logic       self_closed;
    logic [7:0] depth;
    logic       depth_error;
    logic       last_out;

    int         errors;
    int         pending;
    int         checked;
    int         saturations;
    int         peak_depth;

    phase_t     phase     = PH_FREE;
    phase_t     cur_phase = PH_FREE;
    int         hold_count;
    int         quiet;
    int         sent      = 0;
    logic [7:0] doc[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xml_tag_tokenizer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_value  (byte_value),
        .byte_class  (byte_class),
        .name_pos    (name_pos),
        .end_tag     (end_tag),
        .self_closed (self_closed),
        .depth       (depth),
        .depth_error (depth_error),
        .last_out    (last_out)
    );

    xtt_token_checker token_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_value  (byte_value),
        .byte_class  (byte_class),
        .name_pos    (name_pos),
        .end_tag     (end_tag),
        .self_closed (self_closed),
        .depth       (depth),
        .depth_error (depth_error),
        .last_out    (last_out),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .saturations (saturations),
        .peak_depth  (peak_depth)
    );

    // receiver: one long hold-off in the pressure phase, random stalls in the receive-stall and both phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_count <= 0;
        end
        else if (phase == PH_PRESSURE && hold_count < HOLD_LEN)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            case (phase)
                PH_RECV_STALL: out_stall <= ($urandom_range(0, 99) < 49);
                PH_BOTH:       out_stall <= ($urandom_range(0, 99) < 37);
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
        else
            quiet <= 0;
    end

    task automatic set_phase(input phase_t p);
        cur_phase = p;
        phase    <= p;
    endtask

    task automatic send_word(input logic [7:0] b, input logic lst);
        int gap_pct;
        case (cur_phase)
            PH_SEND_IDLE: gap_pct = 49;
            PH_BOTH:      gap_pct = 37;
            default:      gap_pct = 0;
        endcase
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_doc();
        int k;
        for (k = 0; k < doc.size(); k++)
            send_word(doc[k], k == doc.size() - 1);
        doc.delete();
    endtask

    task automatic push_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            doc.push_back(s[k]);
    endtask

    function automatic logic [7:0] one_of(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d);
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return d;
        endcase
    endfunction

    // mostly letters; now and then a bang, slash, dash or any byte
    task automatic push_name();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 85)
                doc.push_back(8'(8'h61 + $urandom_range(0, 25)));
            else
                doc.push_back(one_of(CH_BANG, CH_SLASH, CH_DASH, 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic push_attrs();
        logic [7:0] qc;
        repeat ($urandom_range(1, 3))
        begin
            doc.push_back(one_of(CH_SPACE, CH_LF, CH_TAB, CH_SPACE));
            repeat ($urandom_range(1, 3))
                doc.push_back(8'(8'h61 + $urandom_range(0, 25)));
            if ($urandom_range(0, 3) == 0)
                doc.push_back(CH_SLASH);
            push_str("=");
            qc = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
            doc.push_back(qc);
            repeat ($urandom_range(0, 5))
                doc.push_back(one_of(CH_GT, CH_DQ, CH_SQ, 8'($urandom_range(0, 255))));
            doc.push_back(qc);
        end
    endtask

    task automatic build_doc();
        int         k;
        logic [7:0] b;
        repeat ($urandom_range(1, 8))
        begin
            k = $urandom_range(0, 99);
            if (k < 35)
            begin
                doc.push_back(CH_LT);
                push_name();
                if ($urandom_range(0, 1))
                    push_attrs();
                if ($urandom_range(0, 2) == 0)
                    doc.push_back(CH_SLASH);
                doc.push_back(CH_GT);
            end
            else if (k < 55)
            begin
                push_str("</");
                push_name();
                if ($urandom_range(0, 3) == 0)
                    push_attrs();
                doc.push_back(CH_GT);
            end
            else if (k < 70)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    b = 8'($urandom_range(0, 255));
                    doc.push_back(b == CH_LT ? 8'h78 : b);
                end
            end
            else if (k < 78)
            begin
                push_str("<!--");
                repeat ($urandom_range(0, 6))
                    doc.push_back(one_of(CH_DASH, CH_GT, CH_DASH, 8'h61));
                push_str("-->");
            end
            else if (k < 86)
            begin
                push_str("<![CDATA[");
                repeat ($urandom_range(0, 6))
                    doc.push_back(one_of(CH_RBR, CH_GT, CH_LBR, 8'h78));
                push_str("]]>");
            end
            else if (k < 92)
            begin
                push_str("<!");
                repeat ($urandom_range(0, 5))
                    doc.push_back(one_of(CH_DASH, CH_LBR, 8'h44, 8'($urandom_range(0, 255))));
                doc.push_back(CH_GT);
            end
            else if (k < 95)
                push_str($urandom_range(0, 1) ? "<>" : "< a>");
            else
                repeat ($urandom_range(1, 6))
                    doc.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int doc_idx;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // underflow, empty name, late bang with self-close, dash run in a comment
        set_phase(PH_FREE);
        doc.push_back(8'h00);
        push_str("</x><><a!/><!--->-->");
        doc.push_back(8'hFF);
        send_doc();

        // nest past the top of the depth counter
        repeat ((1 << DEPTH_BITS_DEF) + 2)
        begin
            doc.push_back(CH_LT);
            doc.push_back(8'(8'h61 + $urandom_range(0, 25)));
            doc.push_back(CH_GT);
        end
        push_str("</a></a>");
        send_doc();

        doc_idx = 0;
        while (sent < RANDOM_STOP)
        begin
            if (doc_idx == 3)
            begin
                set_phase(PH_PRESSURE);
                while (doc.size() < 60)
                    build_doc();
            end
            else
            begin
                set_phase(phase_t'(doc_idx % 4));
                build_doc();
            end
            send_doc();
            doc_idx++;
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (8) @(posedge clk);
        $display("sent %0d bytes in %0d streams, %0d words checked under idle/stall/hold-off",
                 sent, doc_idx + 2, checked);
        $display("peak nesting %0d, %0d saturated depth updates", peak_depth, saturations);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/xtt_pkg.sv
rtl/xml_tag_tokenizer_top.sv
tb/xtt_token_checker.sv
tb/tb.sv
